// ===== rtl/core/baa_pkg.sv =====
// Shared types, codes and constants of the bump arena allocator.
package baa_pkg;

    localparam int POOL_TYPES_DEF = 16;
    localparam int SLOTS_PER_POOL_DEF = 64;

    typedef enum logic [3:0] {
        OP_ALLOC    = 4'd0,
        OP_LEGACY   = 4'd1,
        OP_ALIGNED  = 4'd2,
        OP_BUFFER   = 4'd3,
        OP_USED     = 4'd4,
        OP_RELEASE  = 4'd5,
        OP_RESET    = 4'd6,
        OP_FREE     = 4'd7,
        OP_POOL     = 4'd8
    } op_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_OOM     = 2'd2,
        ST_FULL    = 2'd3
    } status_t;

    localparam logic [1:0] REG_ARENA_BASE   = 2'd0;
    localparam logic [1:0] REG_INITIAL_TOP  = 2'd1;
    localparam logic [1:0] REG_MEMORY_LIMIT = 2'd2;

    localparam logic [32:0] BUF_HDR_BYTES = 33'd16;

    typedef struct packed {
        logic [3:0]  operation;
        logic [31:0] request_size;
        logic [31:0] alignment;
        logic [31:0] release_mark;
        logic [63:0] pool_key;
        logic [31:0] slot_bytes;
    } req_t;

    typedef struct packed {
        logic [31:0] result_value;
        logic [1:0]  status;
    } rsp_t;

    // controller -> datapath commands
    typedef struct packed {
        logic load;       // capture request
        logic arena_op;   // execute a non-pool operation
        logic probe_rd;   // read table entry at probe index
        logic probe_cmp;  // evaluate read entry
        logic pool_fin;   // finish pool op
        logic mul_step;   // pool size multiply
        logic done;       // present result
    } cmd_t;

    // datapath -> controller status
    typedef struct packed {
        logic is_pool;
        logic hit;        // empty or matching entry
        logic last_probe;
    } sts_t;

endpackage

// ===== rtl/core/baa_ram.sv =====
// Generic single-port RAM with registered read.
module baa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

// ===== rtl/core/baa_ctrl.sv =====
// Controller state machine of the allocator.
module baa_ctrl
    import baa_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  sts_t sts,
    output logic busy,
    output cmd_t cmd
);
    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_EXEC  = 7'b0000010,
        S_RD    = 7'b0000100,
        S_CMP   = 7'b0001000,
        S_MUL   = 7'b0010000,
        S_FIN   = 7'b0100000,
        S_DONE  = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        busy = (state_reg != S_IDLE);
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.load = start;
                if (start)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (sts.is_pool)
                begin
                    cmd.probe_rd = 1'b1;
                    state_next = S_RD;
                end
                else
                begin
                    cmd.arena_op = 1'b1;
                    state_next = S_DONE;
                end
            end
            S_RD:
            begin
                state_next = S_CMP;
            end
            S_CMP:
            begin
                cmd.probe_cmp = 1'b1;
                if (sts.hit || sts.last_probe)
                begin
                    state_next = S_MUL;
                end
                else
                begin
                    cmd.probe_rd = 1'b1;
                    state_next = S_RD;
                end
            end
            S_MUL:
            begin
                cmd.mul_step = 1'b1;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                cmd.pool_fin = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                cmd.done = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end
endmodule

// ===== rtl/core/baa_dp.sv =====
// Datapath: heap top, arena arithmetic and pool table.
module baa_dp
    import baa_pkg::*;
#(
    parameter int POOL_TYPES = POOL_TYPES_DEF,
    parameter int SLOTS_PER_POOL = SLOTS_PER_POOL_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  req_t        req,
    input  cmd_t        cmd,
    input  logic [31:0] arena_base,
    input  logic [31:0] initial_top,
    input  logic [31:0] memory_limit,
    output sts_t        sts,
    output rsp_t        rsp,
    output logic        rsp_valid
);
    localparam int IW = (POOL_TYPES > 1) ? $clog2(POOL_TYPES) : 1;
    localparam int SW = (SLOTS_PER_POOL > 1) ? $clog2(SLOTS_PER_POOL) : 1;
    localparam int CW = $clog2(POOL_TYPES + 1);
    localparam int ENT_W = 64 + 32 + 32 + SW;
    // pool size and slot offset at full precision
    localparam int TW = 32 + $clog2(SLOTS_PER_POOL + 1);
    localparam int PW = 32 + SW;

    req_t              req_reg;
    logic [31:0]       top_reg;
    logic [31:0]       res_reg;
    logic [1:0]        st_reg;
    logic              valid_reg;
    logic [POOL_TYPES-1:0] pvalid_reg;
    logic [IW-1:0]     idx_reg;
    logic [CW-1:0]     cnt_reg;
    logic              found_reg;
    logic [TW-1:0]     total_reg;
    logic [PW-1:0]     nprod_reg;

    // table entry: key, slot size, base, next slot
    logic              we;
    logic [ENT_W-1:0]  wdata, rdata;
    logic [63:0]       e_key;
    logic [31:0]       e_slot, e_base;
    logic [SW-1:0]     e_next;

    assign {e_key, e_slot, e_base, e_next} = rdata;

    // start index is the low 32 key bits modulo table size
    logic [IW-1:0] start_idx;
    always_comb
    begin
        if (POOL_TYPES == 1)
        begin
            start_idx = '0;
        end
        else
        begin
            start_idx = IW'(req.pool_key[31:0] % 32'(POOL_TYPES));
        end
    end

    logic [IW-1:0] next_idx;
    always_comb
    begin
        if (32'(idx_reg) + 32'd1 >= 32'(POOL_TYPES))
        begin
            next_idx = '0;
        end
        else
        begin
            next_idx = IW'(32'(idx_reg) + 32'd1);
        end
    end

    assign sts.is_pool = (req_reg.operation == OP_POOL);
    assign sts.hit = !pvalid_reg[idx_reg] || (e_key == req_reg.pool_key);
    assign sts.last_probe = (cnt_reg == CW'(POOL_TYPES - 1));

    // arena arithmetic
    logic [33:0] round_in, round_out;
    logic [32:0] al, am1, astart, bstart, btot;
    logic [33:0] end_v;
    logic [31:0] used;
    logic [1:0]  a_st;
    logic [31:0] a_res, a_top;

    always_comb
    begin
        used = top_reg - arena_base;
        al = (req_reg.alignment == 32'd0) ? 33'd1 : {1'b0, req_reg.alignment};
        am1 = al - 33'd1;
        astart = ({1'b0, top_reg} + am1) & ~am1;
        bstart = ({1'b0, top_reg} + 33'd7) & ~33'd7;
        btot = BUF_HDR_BYTES + {1'b0, req_reg.request_size};
        a_st = ST_OK;
        a_res = 32'd0;
        a_top = top_reg;
        end_v = '0;
        case (req_reg.operation)
            OP_ALLOC, OP_LEGACY: end_v = {2'b0, top_reg} + {2'b0, req_reg.request_size};
            OP_ALIGNED: end_v = {1'b0, astart} + {2'b0, req_reg.request_size};
            OP_BUFFER: end_v = {1'b0, bstart} + {1'b0, btot};
            default: end_v = '0;
        endcase
        round_in = end_v;
        round_out = (round_in + 34'd3) & ~34'd3;
        case (req_reg.operation)
            OP_ALLOC, OP_LEGACY, OP_ALIGNED, OP_BUFFER:
            begin
                if (req_reg.operation == OP_ALLOC &&
                    (req_reg.request_size == 32'd0 || req_reg.request_size[31]))
                begin
                    a_st = ST_INVALID;
                end
                else if (req_reg.operation == OP_ALIGNED &&
                         (req_reg.request_size == 32'd0 || (al & am1) != 33'd0))
                begin
                    a_st = ST_INVALID;
                end
                else if (req_reg.operation == OP_BUFFER && btot[32])
                begin
                    a_st = ST_INVALID;
                end
                else if ((req_reg.operation == OP_ALIGNED && astart[32]) ||
                         (req_reg.operation == OP_BUFFER && bstart[32]) ||
                         round_out > {2'b0, memory_limit})
                begin
                    a_st = ST_OOM;
                end
                else
                begin
                    a_top = round_out[31:0];
                    case (req_reg.operation)
                        OP_ALIGNED: a_res = astart[31:0];
                        OP_BUFFER:  a_res = bstart[31:0];
                        default:    a_res = top_reg;
                    endcase
                end
            end
            OP_USED: a_res = used;
            OP_RELEASE:
            begin
                if (req_reg.release_mark > used)
                begin
                    a_st = ST_INVALID;
                end
                else
                begin
                    a_top = arena_base + req_reg.release_mark;
                end
            end
            OP_RESET: a_top = arena_base;
            OP_FREE: a_st = ST_OK;
            default: a_st = ST_INVALID;
        endcase
    end

    // pool finish
    logic [33:0] pbase, pend, pend_r;
    logic [31:0] p_slot_sz;
    logic [SW-1:0] p_n, p_n1;
    logic [31:0] p_base32;
    logic [63:0] p_addr;
    logic [1:0]  p_st;
    logic        p_new;

    always_comb
    begin
        p_new = !pvalid_reg[idx_reg];
        pbase = ({2'b0, top_reg} + 34'd7) & ~34'd7;
        pend = pbase + {2'b0, total_reg[31:0]};
        pend_r = (pend + 34'd3) & ~34'd3;
        p_n = p_new ? '0 : e_next;
        p_n1 = (32'(p_n) + 32'd1 >= 32'(SLOTS_PER_POOL)) ? '0 : SW'(32'(p_n) + 32'd1);
        p_base32 = p_new ? pbase[31:0] : e_base;
        p_slot_sz = req_reg.slot_bytes;
        p_addr = {32'd0, p_base32} + 64'(nprod_reg);
        p_st = ST_OK;
        if (req_reg.slot_bytes == 32'd0)
        begin
            p_st = ST_INVALID;
        end
        else if (!found_reg)
        begin
            p_st = ST_FULL;
        end
        else if (p_new)
        begin
            if (total_reg[TW-1:32] != '0 || pend[33:32] != 2'b0 ||
                pend_r > {2'b0, memory_limit})
            begin
                p_st = ST_OOM;
            end
        end
        else if (e_slot != req_reg.slot_bytes)
        begin
            p_st = ST_INVALID;
        end
        if (p_st == ST_OK && p_addr[63:32] != 32'd0)
        begin
            p_st = ST_OOM;
        end
    end

    assign we = cmd.pool_fin && (p_st == ST_OK);
    assign wdata = {req_reg.pool_key, p_slot_sz, p_base32, p_n1};

    baa_ram #(.WIDTH(ENT_W), .DEPTH(POOL_TYPES)) u_tab (
        .clk(clk),
        .we(we),
        .addr(cmd.probe_rd ? (cmd.probe_cmp ? next_idx : idx_reg) : idx_reg),
        .wdata(wdata),
        .rdata(rdata)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg <= req;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top_reg <= initial_top;
            res_reg <= '0;
            st_reg <= ST_OK;
            valid_reg <= 1'b0;
            pvalid_reg <= '0;
            idx_reg <= '0;
            cnt_reg <= '0;
            found_reg <= 1'b0;
            total_reg <= '0;
            nprod_reg <= '0;
        end
        else
        begin
            valid_reg <= cmd.done;
            if (cmd.load)
            begin
                idx_reg <= start_idx;
                cnt_reg <= '0;
                found_reg <= 1'b0;
            end
            if (cmd.arena_op)
            begin
                top_reg <= a_top;
                st_reg <= a_st;
                res_reg <= (a_st == ST_OK) ? a_res : 32'd0;
            end
            if (cmd.probe_cmp)
            begin
                found_reg <= sts.hit;
                if (!sts.hit && !sts.last_probe)
                begin
                    idx_reg <= next_idx;
                    cnt_reg <= cnt_reg + CW'(1);
                end
            end
            // pool size and offset of the handed-out slot
            if (cmd.mul_step)
            begin
                total_reg <= TW'(SLOTS_PER_POOL) * TW'(req_reg.slot_bytes);
                nprod_reg <= PW'(p_n) * PW'(req_reg.slot_bytes);
            end
            if (cmd.pool_fin)
            begin
                st_reg <= p_st;
                res_reg <= (p_st == ST_OK) ? p_addr[31:0] : 32'd0;
                if (p_st == ST_OK && p_new)
                begin
                    pvalid_reg[idx_reg] <= 1'b1;
                    top_reg <= pend_r[31:0];
                end
            end
        end
    end

    assign rsp.result_value = res_reg;
    assign rsp.status = st_reg;
    assign rsp_valid = valid_reg;
endmodule

// ===== rtl/core/bump_arena_allocator_with_pools.sv =====
// Top level of the bump arena allocator with slot pools.
//  channel  | signals                         | transfer when
//  request  | start, busy, req                | start && !busy
//  result   | done, rsp                       | done (one cycle, no stall)
//  config   | cfg_valid, cfg_ready, cfg_index | cfg_valid && cfg_ready
// Arena operations pass through the EXEC and DONE states. Pool allocation
// passes EXEC, then probes the table serially through the single-port pool
// memory, an RD and a CMP state per probe, then passes MUL, FIN and DONE.
// Reset loads initial_top into the heap top and clears pool valid bits.
// The result cannot be stalled; busy holds off new requests.
module bump_arena_allocator_with_pools
    import baa_pkg::*;
#(
    parameter int POOL_TYPES = POOL_TYPES_DEF,
    parameter int SLOTS_PER_POOL = SLOTS_PER_POOL_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  req_t        req,
    output logic        done,
    output rsp_t        rsp,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    logic [31:0] arena_base_reg, initial_top_reg, memory_limit_reg;
    cmd_t cmd;
    sts_t sts;

    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            arena_base_reg <= '0;
            initial_top_reg <= '0;
            memory_limit_reg <= '1;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_ARENA_BASE:   arena_base_reg <= cfg_data;
                REG_INITIAL_TOP:  initial_top_reg <= cfg_data;
                REG_MEMORY_LIMIT: memory_limit_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    baa_ctrl u_ctrl (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .sts(sts),
        .busy(busy),
        .cmd(cmd)
    );

    baa_dp #(.POOL_TYPES(POOL_TYPES), .SLOTS_PER_POOL(SLOTS_PER_POOL)) u_dp (
        .clk(clk),
        .rst_n(rst_n),
        .req(req),
        .cmd(cmd),
        .arena_base(arena_base_reg),
        .initial_top(initial_top_reg),
        .memory_limit(memory_limit_reg),
        .sts(sts),
        .rsp(rsp),
        .rsp_valid(done)
    );
endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for the bump arena allocator with slot pools.
module tb_top;
    import baa_pkg::*;

    localparam int TABLE_SIZE = POOL_TYPES_DEF;
    localparam int POOL_SLOTS = SLOTS_PER_POOL_DEF;
    localparam logic [3:0] OP_UNKNOWN_LO = 4'd9;
    localparam logic [3:0] OP_UNKNOWN_HI = 4'd15;
    localparam logic [63:0] U32_TOP = 64'h0000_0000_FFFF_FFFF;
    localparam int SETTLE_CYCLES = 60;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    req_t        req;
    logic        done;
    rsp_t        rsp;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;

    bump_arena_allocator_with_pools dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req       (req),
        .done      (done),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Predictor state: registers, heap top and the pool table
    logic [31:0] base_reg;
    logic [31:0] init_top_reg;
    logic [31:0] limit_reg;
    logic [31:0] top_now;
    logic        slot_used  [TABLE_SIZE];
    logic [63:0] slot_key   [TABLE_SIZE];
    logic [31:0] slot_width [TABLE_SIZE];
    logic [31:0] slot_start [TABLE_SIZE];
    int          slot_next  [TABLE_SIZE];

    rsp_t pending_rsp[$];
    int   fail_count;
    bit   quiet;

    // Directed stimulus row
    typedef struct {
        req_t        item;
        bit          typed;
        logic [31:0] want_value;
        status_t     want_status;
    } vector_t;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        #50_000_000;
        $display("Some tests failed");
        $finish;
    end

    // Bump the top to a new end, rounded to 4; out of memory past the limit
    function automatic status_t grow_top(logic [63:0] end_addr);
        logic [63:0] rounded;
        rounded = (end_addr + 64'd3) & ~64'd3;
        if (rounded > {32'd0, limit_reg})
            return ST_OOM;
        top_now = rounded[31:0];
        return ST_OK;
    endfunction

    function automatic rsp_t predict_pool(req_t r);
        rsp_t        o;
        int          idx;
        int          first;
        bit          hit;
        logic [63:0] total;
        logic [63:0] pbase;
        logic [63:0] addr;
        o = '{result_value: 32'd0, status: ST_OK};
        hit = 1'b0;
        idx = 0;
        if (r.slot_bytes == 32'd0) begin
            o.status = ST_INVALID;
            return o;
        end
        first = r.pool_key[31:0] % TABLE_SIZE;
        for (int p = 0; p < TABLE_SIZE && !hit; p++) begin
            idx = (first + p) % TABLE_SIZE;
            hit = !slot_used[idx] || slot_key[idx] == r.pool_key;
        end
        if (!hit) begin
            o.status = ST_FULL;
            return o;
        end
        if (!slot_used[idx]) begin
            total = 64'(POOL_SLOTS) * {32'd0, r.slot_bytes};
            pbase = ({32'd0, top_now} + 64'd7) & ~64'd7;
            if (total > U32_TOP || pbase + total > U32_TOP
                    || grow_top(pbase + total) != ST_OK) begin
                o.status = ST_OOM;
                return o;
            end
            slot_used[idx]  = 1'b1;
            slot_key[idx]   = r.pool_key;
            slot_width[idx] = r.slot_bytes;
            slot_next[idx]  = 0;
            slot_start[idx] = pbase[31:0];
        end else if (slot_width[idx] != r.slot_bytes) begin
            o.status = ST_INVALID;
            return o;
        end
        addr = {32'd0, slot_start[idx]} + 64'(slot_next[idx]) * {32'd0, r.slot_bytes};
        slot_next[idx] = (slot_next[idx] + 1) % POOL_SLOTS;
        if (addr > U32_TOP)
            o.status = ST_OOM;
        else
            o.result_value = addr[31:0];
        return o;
    endfunction

    // Expected result of one request; updates the predictor state
    function automatic rsp_t predict_arena(req_t r);
        rsp_t        o;
        logic [31:0] old;
        logic [31:0] al;
        logic [63:0] s;
        logic [63:0] total;
        o = '{result_value: 32'd0, status: ST_OK};
        old = top_now;
        case (r.operation)
            OP_ALLOC: begin
                if (r.request_size == 32'd0 || r.request_size[31]) begin
                    o.status = ST_INVALID;
                end else begin
                    o.status = grow_top({32'd0, old} + {32'd0, r.request_size});
                    o.result_value = old;
                end
            end
            OP_LEGACY: begin
                o.status = grow_top({32'd0, old} + {32'd0, r.request_size});
                o.result_value = old;
            end
            OP_ALIGNED: begin
                al = (r.alignment == 32'd0) ? 32'd1 : r.alignment;
                if (r.request_size == 32'd0 || (al & (al - 32'd1)) != 32'd0) begin
                    o.status = ST_INVALID;
                end else begin
                    s = ({32'd0, old} + {32'd0, al} - 64'd1) & ~({32'd0, al} - 64'd1);
                    if (s > U32_TOP) begin
                        o.status = ST_OOM;
                    end else begin
                        o.status = grow_top(s + {32'd0, r.request_size});
                        o.result_value = s[31:0];
                    end
                end
            end
            OP_BUFFER: begin
                total = 64'd16 + {32'd0, r.request_size};
                s = ({32'd0, old} + 64'd7) & ~64'd7;
                if (total > U32_TOP) begin
                    o.status = ST_INVALID;
                end else if (s > U32_TOP) begin
                    o.status = ST_OOM;
                end else begin
                    o.status = grow_top(s + total);
                    o.result_value = s[31:0];
                end
            end
            OP_USED: o.result_value = top_now - base_reg;
            OP_RELEASE: begin
                if (r.release_mark > top_now - base_reg)
                    o.status = ST_INVALID;
                else
                    top_now = base_reg + r.release_mark;
            end
            OP_RESET: top_now = base_reg;
            OP_FREE: ;
            OP_POOL: o = predict_pool(r);
            default: o.status = ST_INVALID;
        endcase
        if (o.status != ST_OK)
            o.result_value = 32'd0;
        return o;
    endfunction

    // Result checker: every done strobe is one transfer
    always @(posedge clk) begin
        rsp_t want;
        if (rst_n && done) begin
            if (pending_rsp.size() == 0) begin
                $error("unexpected result value=%h status=%0d",
                       rsp.result_value, rsp.status);
                fail_count++;
            end else begin
                want = pending_rsp.pop_front();
                if (rsp.result_value !== want.result_value) begin
                    $error("result_value expected %h actual %h",
                           want.result_value, rsp.result_value);
                    fail_count++;
                end
                if (rsp.status !== want.status) begin
                    $error("status expected %0d actual %0d", want.status, rsp.status);
                    fail_count++;
                end
            end
        end
    end

    function automatic int pick_gap();
        int roll;
        if (quiet)
            return 0;
        roll = $urandom_range(99);
        if (roll < 65)
            return 0;
        if (roll < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Present one request from a falling edge until it is taken
    task automatic issue_request(req_t r, output rsp_t predicted);
        start = 1'b1;
        req = r;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        predicted = predict_arena(r);
        pending_rsp.push_back(predicted);
        @(negedge clk);
    endtask

    task automatic send_with_gap(req_t r, output rsp_t predicted);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            start = 1'b0;
            repeat (gap) @(negedge clk);
        end
        issue_request(r, predicted);
    endtask

    task automatic drain_results();
        start = 1'b0;
        while (pending_rsp.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_register(logic [1:0] idx, logic [31:0] value);
        repeat (pick_gap()) @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            REG_ARENA_BASE:   base_reg = value;
            REG_INITIAL_TOP:  init_top_reg = value;
            REG_MEMORY_LIMIT: limit_reg = value;
            default: ;
        endcase
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    function automatic req_t blank_req(logic [3:0] op);
        req_t r;
        r = '0;
        r.operation = op;
        return r;
    endfunction

    function automatic logic [31:0] rand_size();
        int roll;
        roll = $urandom_range(99);
        if (roll < 75)
            return $urandom_range(1, 200);
        if (roll < 85)
            return 32'd0;
        if (roll < 92)
            return $urandom_range(1, 1 << 20);
        return $urandom();
    endfunction

    // Random request, biased toward well-formed arena and pool traffic
    function automatic req_t random_req();
        req_t r;
        int   roll;
        r.request_size = rand_size();
        r.alignment = ($urandom_range(9) == 0) ? $urandom() : (32'd1 << $urandom_range(0, 31));
        if ($urandom_range(5) == 0)
            r.alignment = 32'd0;
        r.release_mark = $urandom();
        r.pool_key = {$urandom(), $urandom()};
        r.slot_bytes = $urandom();
        roll = $urandom_range(99);
        if (roll < 15)
            r.operation = OP_ALLOC;
        else if (roll < 25)
            r.operation = OP_LEGACY;
        else if (roll < 35)
            r.operation = OP_ALIGNED;
        else if (roll < 43)
            r.operation = OP_BUFFER;
        else if (roll < 50)
            r.operation = OP_USED;
        else if (roll < 58)
            r.operation = OP_RELEASE;
        else if (roll < 62)
            r.operation = OP_RESET;
        else if (roll < 65)
            r.operation = OP_FREE;
        else if (roll < 97)
            r.operation = OP_POOL;
        else
            r.operation = 4'($urandom_range(OP_UNKNOWN_LO, OP_UNKNOWN_HI));
        // Release mostly within the used span
        if (r.operation == OP_RELEASE && $urandom_range(3) != 0)
            r.release_mark = (top_now - base_reg) == 0 ? 32'd0
                           : $urandom_range(0, top_now - base_reg);
        // Pools: a small key set so entries repeat, fill and collide
        if (r.operation == OP_POOL && $urandom_range(9) != 0) begin
            r.pool_key = {($urandom_range(1) ? $urandom() : 32'd0), 32'($urandom_range(0, 23))};
            r.slot_bytes = (r.pool_key[3:0] + 1) * 4;
            if ($urandom_range(15) == 0)
                r.slot_bytes = $urandom_range(0, 64);
        end
        return r;
    endfunction

    initial begin
        vector_t     vec[$];
        vector_t     v;
        req_t        r;
        rsp_t        got;
        logic [31:0] bases[5];
        logic [31:0] limits[5];

        fail_count = 0;
        quiet = 1'b0;
        start = 1'b0;
        req = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_ARENA_BASE;
        cfg_data = 32'd0;
        base_reg = 32'd0;
        init_top_reg = 32'd0;
        limit_reg = 32'hFFFF_FFFF;
        top_now = 32'd0;
        for (int i = 0; i < TABLE_SIZE; i++) begin
            slot_used[i] = 1'b0;
            slot_key[i] = '0;
            slot_width[i] = '0;
            slot_start[i] = '0;
            slot_next[i] = 0;
        end
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        repeat (SETTLE_CYCLES) @(negedge clk);

        // Directed table: fresh arena at top 0, full memory limit
        v = '{blank_req(OP_USED), 1, 32'd0, ST_OK};                 vec.push_back(v);
        v = '{blank_req(OP_ALLOC), 1, 32'd0, ST_INVALID};           vec.push_back(v);
        r = blank_req(OP_ALLOC); r.request_size = 32'h8000_0000;
        v = '{r, 1, 32'd0, ST_INVALID};                             vec.push_back(v);
        r = blank_req(OP_ALLOC); r.request_size = 32'd5;
        v = '{r, 1, 32'd0, ST_OK};                                  vec.push_back(v);
        v = '{blank_req(OP_LEGACY), 1, 32'd8, ST_OK};               vec.push_back(v);
        r = blank_req(OP_ALIGNED); r.request_size = 32'd1; r.alignment = 32'd3;
        v = '{r, 1, 32'd0, ST_INVALID};                             vec.push_back(v);
        r = blank_req(OP_ALIGNED); r.request_size = 32'd4;
        v = '{r, 0, 32'd0, ST_OK};                                  vec.push_back(v);
        r = blank_req(OP_ALIGNED); r.request_size = 32'd1; r.alignment = 32'h8000_0000;
        v = '{r, 0, 32'd0, ST_OK};                                  vec.push_back(v);
        r = blank_req(OP_BUFFER); r.request_size = 32'hFFFF_FFF0;
        v = '{r, 1, 32'd0, ST_INVALID};                             vec.push_back(v);
        r = blank_req(OP_BUFFER); r.request_size = 32'hFFFF_FFEF;
        v = '{r, 0, 32'd0, ST_OK};                                  vec.push_back(v);
        r = blank_req(OP_LEGACY); r.request_size = 32'hFFFF_FFFF;
        v = '{r, 0, 32'd0, ST_OK};                                  vec.push_back(v);
        r = blank_req(OP_RELEASE); r.release_mark = 32'hFFFF_FFFF;
        v = '{r, 0, 32'd0, ST_OK};                                  vec.push_back(v);
        v = '{blank_req(OP_RELEASE), 1, 32'd0, ST_OK};              vec.push_back(v);
        v = '{blank_req(OP_USED), 1, 32'd0, ST_OK};                 vec.push_back(v);
        r = blank_req(OP_BUFFER); r.request_size = 32'd3;
        v = '{r, 1, 32'd0, ST_OK};                                  vec.push_back(v);
        v = '{blank_req(OP_RESET), 1, 32'd0, ST_OK};                vec.push_back(v);
        v = '{blank_req(OP_FREE), 1, 32'd0, ST_OK};                 vec.push_back(v);
        v = '{blank_req(OP_POOL), 1, 32'd0, ST_INVALID};            vec.push_back(v);
        r = blank_req(OP_POOL); r.pool_key = 64'hFFFF_FFFF_FFFF_FFFF; r.slot_bytes = 32'd8;
        v = '{r, 0, 32'd0, ST_OK};                                  vec.push_back(v);
        v = '{r, 0, 32'd0, ST_OK};                                  vec.push_back(v);
        r.slot_bytes = 32'd16;
        v = '{r, 1, 32'd0, ST_INVALID};                             vec.push_back(v);
        r = blank_req(OP_POOL); r.pool_key = 64'd3; r.slot_bytes = 32'hFFFF_FFFF;
        v = '{r, 1, 32'd0, ST_OOM};                                 vec.push_back(v);
        v = '{blank_req(OP_UNKNOWN_LO), 1, 32'd0, ST_INVALID};      vec.push_back(v);
        v = '{blank_req(OP_UNKNOWN_HI), 1, 32'd0, ST_INVALID};      vec.push_back(v);

        foreach (vec[i]) begin
            send_with_gap(vec[i].item, got);
            if (vec[i].typed && (got.result_value !== vec[i].want_value
                    || got.status !== vec[i].want_status)) begin
                $error("directed row %0d: predictor gives %h/%0d, table %h/%0d", i,
                       got.result_value, got.status, vec[i].want_value, vec[i].want_status);
                fail_count++;
            end
        end
        drain_results();

        // Random phases, each under its own register setting
        bases  = '{32'd0, 32'hFFFF_FFFF, 32'h0000_1000, 32'h8000_0000, 32'd0};
        limits = '{32'hFFFF_FFFF, 32'd0, 32'h0001_0000, 32'hFFFF_FFFF, 32'h0004_0000};
        for (int ph = 0; ph < 10; ph++) begin
            write_register(REG_ARENA_BASE, (ph < 5) ? bases[ph] : $urandom());
            write_register(REG_INITIAL_TOP, (ph % 3 == 0) ? 32'hFFFF_FFFF : $urandom());
            write_register(REG_MEMORY_LIMIT,
                           (ph < 5) ? limits[ph] : $urandom_range(32'h100, 32'h00FF_FFFF));
            quiet = (ph % 4 == 1);
            // Start each phase from the arena base so allocations have room
            send_with_gap(blank_req(OP_RESET), got);
            for (int n = 0; n < 188; n++)
                send_with_gap(random_req(), got);
            drain_results();
        end

        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
